// ===== sv/assert_macros.svh =====
// assertion macros shared by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	`ASSERT_PROP(lbl, clk, rstn, !(cond))

`endif

// ===== sv/ckc_pkg.sv =====
// types, constants and codes of the color key centroid tracker
`default_nettype none

package ckc_pkg;

	localparam int NUM_MK    = 4;
	localparam int MK_W      = $clog2(NUM_MK);
	localparam int NUM_CH    = 3;
	localparam int CH_W      = 8;
	localparam int CRD_W     = 11;
	localparam int BOX_W     = 2 * NUM_CH * CH_W;
	localparam int SUM_W     = 34;
	localparam int CNT_W     = 23;
	localparam int CENT_W    = 15;
	localparam int FRAC_BITS = 4;
	localparam int DIV_W     = SUM_W + FRAC_BITS;
	localparam int DSR_W     = CNT_W + CENT_W;
	localparam int CMP_W     = (DIV_W > DSR_W) ? DIV_W : DSR_W;
	localparam int STEP_W    = $clog2(CENT_W + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [BOX_W-1:0] BOX_RESET [NUM_MK] = '{
		48'd176869697172630,
		48'd155031122790600,
		48'd143563145904810,
		48'd280677293752320
	};

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_REC   = 1'b1;

	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic            step;
		logic            clear;
		logic [MK_W-1:0] idx;
	} acc_ctrl_t;

	typedef struct packed {
		logic [1:0]       pad;
		logic [CRD_W-1:0] row;
		logic [CRD_W-1:0] col;
		pix_t             px;
	} in_data_t;

	typedef struct packed {
		logic              no_hits;
		logic [CNT_W-1:0]  hit_count;
		logic [CENT_W-1:0] cy;
		logic [CENT_W-1:0] cx;
		logic [MK_W-1:0]   marker;
		pix_t              px;
	} out_data_t;

	localparam int IN_W  = $bits(in_data_t);
	localparam int OUT_W = $bits(out_data_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_ECHO,
		ST_LOADX,
		ST_DIVX,
		ST_DIVY,
		ST_REC
	} state_t;

endpackage

`default_nettype wire

// ===== sv/color_key_centroid_tracker.sv =====
// top level: sequencer, pixel and output registers of the centroid tracker
`default_nettype none

// Each pixel is checked against the four marker boxes one marker per cycle in a
// single shared box compare, so a pixel goes from accept through four match steps
// to the output load, which waits until the output register is free. A new
// pixel is accepted while the previous echo still waits in the output register.
// On an end-of-frame pixel the echo is followed by four centroid records; each
// record runs the shared restoring divider twice, once per coordinate, and the
// next pixel is taken only after the last record is loaded.
module color_key_centroid_tracker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ckc_pkg::MK_W-1:0]    cfg_index,
	input  wire logic [ckc_pkg::BOX_W-1:0]   cfg_data,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// chan0_in, chan1_in, chan2_in, col, row, zero fill
	input  wire logic [ckc_pkg::IN_W-1:0]    s_tdata,
	input  wire logic                        s_tlast,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// chan0_out, chan1_out, chan2_out, marker, centroid_x, centroid_y,
	// hit_count, no_hits
	output logic [ckc_pkg::OUT_W-1:0]        m_tdata,
	// kind
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import ckc_pkg::*;

	`include "assert_macros.svh"

	state_t            state_q, state_d;
	in_data_t          in_d;
	pix_t              px_q;
	logic [CRD_W-1:0]  col_q, row_q;
	logic              eof_q;
	logic [MK_W-1:0]   idx_q;
	logic [CENT_W-1:0] cx_q, cy_q;

	out_data_t         out_q;
	logic              out_valid_q, out_kind_q, out_last_q;
	logic              out_free;

	acc_ctrl_t         acc_ctl;
	logic              hit;
	logic [SUM_W-1:0]  sum_col, sum_row;
	logic [CNT_W-1:0]  count;

	logic              div_start, div_sel_row, div_busy, div_done;
	logic [DIV_W-1:0]  dividend;
	logic [CENT_W-1:0] quot;

	logic              accept, load_echo, load_rec;

	assign in_d     = in_data_t'(s_tdata);
	assign out_free = !out_valid_q || m_tready;

	ckc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (acc_ctl),
		.px        (px_q),
		.col       (col_q),
		.row       (row_q),
		.hit       (hit),
		.sum_col   (sum_col),
		.sum_row   (sum_row),
		.count     (count)
	);

	assign dividend = div_sel_row ? (DIV_W'(sum_row) << FRAC_BITS)
	                              : (DIV_W'(sum_col) << FRAC_BITS);

	ckc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				if (idx_q == MK_W'(NUM_MK - 1)) state_d = ST_ECHO;
			end
			ST_ECHO: begin
				if (out_free) state_d = eof_q ? ST_LOADX : ST_IDLE;
			end
			ST_LOADX: begin
				state_d = ST_DIVX;
			end
			ST_DIVX: begin
				if (div_done) state_d = ST_DIVY;
			end
			ST_DIVY: begin
				if (div_done) state_d = ST_REC;
			end
			ST_REC: begin
				if (out_free) state_d = (idx_q == MK_W'(NUM_MK - 1)) ? ST_IDLE : ST_LOADX;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready      = 1'b0;
		acc_ctl.step  = 1'b0;
		acc_ctl.clear = 1'b0;
		acc_ctl.idx   = idx_q;
		div_start     = 1'b0;
		div_sel_row   = 1'b0;
		load_echo     = 1'b0;
		load_rec      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_MATCH: acc_ctl.step = 1'b1;
			ST_ECHO:  load_echo = out_free;
			ST_LOADX: div_start = 1'b1;
			ST_DIVX: begin
				div_start   = div_done;
				div_sel_row = 1'b1;
			end
			ST_DIVY: ;
			ST_REC: begin
				load_rec      = out_free;
				acc_ctl.clear = out_free && (idx_q == MK_W'(NUM_MK - 1));
			end
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || load_echo) begin
				idx_q <= '0;
			end else if (state_q == ST_MATCH || load_rec) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_echo || load_rec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= in_d.px;
			col_q <= in_d.col;
			row_q <= in_d.row;
			eof_q <= s_tlast;
		end else if (state_q == ST_MATCH && hit) begin
			// a matched pixel goes black before the next marker looks at it
			px_q <= '0;
		end
		if (state_q == ST_DIVX && div_done) cx_q <= quot;
		if (state_q == ST_DIVY && div_done) cy_q <= quot;
		if (load_echo) begin
			out_q.px        <= px_q;
			out_q.marker    <= '0;
			out_q.cx        <= '0;
			out_q.cy        <= '0;
			out_q.hit_count <= '0;
			out_q.no_hits   <= 1'b0;
			out_kind_q      <= KIND_PIXEL;
			out_last_q      <= !eof_q;
		end else if (load_rec) begin
			out_q.px        <= '0;
			out_q.marker    <= idx_q;
			out_q.cx        <= (count == '0) ? '0 : cx_q;
			out_q.cy        <= (count == '0) ? '0 : cy_q;
			out_q.hit_count <= count;
			out_q.no_hits   <= (count == '0);
			out_kind_q      <= KIND_REC;
			out_last_q      <= (idx_q == MK_W'(NUM_MK - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`ASSERT_NEVER(a_idle_div_busy, clk, arst_n, s_tready && div_busy)
	`ASSERT_PROP(a_load_free, clk, arst_n, (load_echo || load_rec) |-> out_free)
	`ASSERT_PROP(a_empty_zero, clk, arst_n,
		(out_valid_q && out_kind_q == KIND_REC && out_q.no_hits) |->
		(out_q.cx == '0 && out_q.cy == '0 && out_q.hit_count == '0))

endmodule

`default_nettype wire

// ===== sv/ckc_div.sv =====
// restoring divider, one quotient bit per cycle, saturating quotient
`default_nettype none

module ckc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ckc_pkg::DIV_W-1:0]   dividend,
	input  wire logic [ckc_pkg::CNT_W-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic [ckc_pkg::CENT_W-1:0]       quot
);
	import ckc_pkg::*;

	`include "assert_macros.svh"

	logic [CMP_W-1:0]  rem_q;
	logic [CMP_W-1:0]  dsr_q;
	logic [CENT_W:0]   quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CENT_W);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// first step tests against divisor << CENT_W, which flags saturation
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CMP_W'(dividend);
			dsr_q <= CMP_W'(divisor) << CENT_W;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[CENT_W-1:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q[CENT_W] ? {CENT_W{1'b1}} : quo_q[CENT_W-1:0];

	`ASSERT_PROP(a_start_busy, clk, arst_n, start |=> busy_q)
	`ASSERT_PROP(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`ASSERT_NEVER(a_done_busy, clk, arst_n, done_q && busy_q)

endmodule

`default_nettype wire

// ===== sv/ckc_accum.sv =====
// marker boxes, shared box compare and per-marker sums and counts
`default_nettype none

module ckc_accum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ckc_pkg::MK_W-1:0]    cfg_index,
	input  wire logic [ckc_pkg::BOX_W-1:0]   cfg_data,
	input  wire ckc_pkg::acc_ctrl_t          ctl,
	input  wire ckc_pkg::pix_t               px,
	input  wire logic [ckc_pkg::CRD_W-1:0]   col,
	input  wire logic [ckc_pkg::CRD_W-1:0]   row,
	output logic                             hit,
	output logic [ckc_pkg::SUM_W-1:0]        sum_col,
	output logic [ckc_pkg::SUM_W-1:0]        sum_row,
	output logic [ckc_pkg::CNT_W-1:0]        count
);
	import ckc_pkg::*;

	logic [BOX_W-1:0] box_q     [NUM_MK];
	logic [SUM_W-1:0] sum_col_q [NUM_MK];
	logic [SUM_W-1:0] sum_row_q [NUM_MK];
	logic [CNT_W-1:0] cnt_q     [NUM_MK];
	logic [BOX_W-1:0] box;

	assign box = box_q[ctl.idx];

	// lower bounds in bytes 0..2, upper bounds in bytes 3..5
	always_comb begin
		hit = 1'b1;
		for (int c = 0; c < NUM_CH; c++) begin
			if (px[c] < box[c*CH_W +: CH_W] || px[c] > box[(c+NUM_CH)*CH_W +: CH_W]) begin
				hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MK; i++) begin
				box_q[i]     <= BOX_RESET[i];
				sum_col_q[i] <= '0;
				sum_row_q[i] <= '0;
				cnt_q[i]     <= '0;
			end
		end else begin
			if (cfg_we) begin
				box_q[cfg_index] <= cfg_data;
			end
			if (ctl.clear) begin
				for (int i = 0; i < NUM_MK; i++) begin
					sum_col_q[i] <= '0;
					sum_row_q[i] <= '0;
					cnt_q[i]     <= '0;
				end
			end else if (ctl.step && hit && cnt_q[ctl.idx] != CNT_MAX) begin
				sum_col_q[ctl.idx] <= sum_col_q[ctl.idx] + SUM_W'(col);
				sum_row_q[ctl.idx] <= sum_row_q[ctl.idx] + SUM_W'(row);
				cnt_q[ctl.idx]     <= cnt_q[ctl.idx] + 1'b1;
			end
		end
	end

	assign sum_col = sum_col_q[ctl.idx];
	assign sum_row = sum_row_q[ctl.idx];
	assign count   = cnt_q[ctl.idx];

endmodule

`default_nettype wire

// ===== sim/color_key_centroid_tracker_tb.sv =====
// testbench of the color key centroid tracker: directed stimulus table, then random frames
`default_nettype none

module color_key_centroid_tracker_tb;
	import ckc_pkg::*;

	typedef struct packed {
		logic      kind;
		logic      last;
		out_data_t d;
	} result_t;

	typedef struct packed {
		logic             is_cfg;
		logic [MK_W-1:0]  idx;
		logic [BOX_W-1:0] box;
		logic [CH_W-1:0]  c0, c1, c2;
		logic [CRD_W-1:0] col, row;
		logic             eof;
		logic             typed;
		logic [CH_W-1:0]  e0, e1, e2;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	localparam int N_STIM = 23;

	// config rows carry a box, pixel rows carry the pixel and, where typed, its echo
	stim_row_t stim_tab [N_STIM] = '{
		// reset boxes: hits on each marker, misses, box edges, lone end-of-frame pixels
		'{1'b0, 2'd0, 48'd0, 8'd160, 8'd200, 8'd140, 11'd0, 11'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd0, 8'd0, 8'd0, 11'd2047, 11'd2047, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd255, 8'd255, 8'd255, 11'd2047, 11'd0, 1'b0, 1'b1,
			8'd255, 8'd255, 8'd255},
		'{1'b0, 2'd0, 48'd0, 8'd220, 8'd220, 8'd100, 11'd5, 11'd9, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd200, 8'd140, 8'd100, 11'd100, 11'd50, 1'b0, 1'b1,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd30, 8'd30, 8'd200, 11'd2047, 11'd2047, 1'b0, 1'b1,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd175, 8'd220, 8'd160, 11'd1, 11'd2, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd150, 8'd180, 8'd120, 11'd3, 11'd4, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd149, 8'd180, 8'd120, 11'd0, 11'd0, 1'b1, 1'b1,
			8'd149, 8'd180, 8'd120},
		// full box, black point box fed by blackened pixels, empty box, full box
		'{1'b1, 2'd0, 48'hFFFFFF_000000, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd1, 48'h000000_000000, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd2, 48'hFFFF05_00000A, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd3, 48'hFFFFFF_000000, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd1, 8'd2, 8'd3, 11'd7, 11'd8, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b0, 1'b1,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd0, 8'd0, 8'd0, 11'd0, 11'd2047, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0},
		// point boxes at both extremes and an inverted all-channel box
		'{1'b1, 2'd0, 48'h000000_000000, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd1, 48'hFFFFFF_FFFFFF, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd2, 48'h000000_FFFFFF, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b1, 2'd3, 48'h000000_000000, 8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b0, 1'b0,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd255, 8'd255, 8'd255, 11'd2047, 11'd1024, 1'b0, 1'b1,
			8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd0, 8'd0, 8'd0, 11'd1024, 11'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0},
		'{1'b0, 2'd0, 48'd0, 8'd0, 8'd255, 8'd0, 11'd513, 11'd1366, 1'b1, 1'b1,
			8'd0, 8'd255, 8'd0}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [MK_W-1:0]     cfg_index = '0;
	logic [BOX_W-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	in_data_t            s_tdata   = '0;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	// own copy of the block state
	logic [BOX_W-1:0] box_reg   [NUM_MK];
	logic [SUM_W-1:0] col_sum   [NUM_MK];
	logic [SUM_W-1:0] row_sum   [NUM_MK];
	logic [CNT_W-1:0] hit_tally [NUM_MK];

	result_t  pending_results[$];
	int       err_count    = 0;
	int       pix_accepted = 0;
	int       burst_left   = 0;
	int       rx_cyc       = 0;
	logic     rx_hold      = 1'b0;
	rx_mode_t rx_mode      = RX_OPEN;

	color_key_centroid_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic logic [CENT_W-1:0] scaled_mean(logic [SUM_W-1:0] sum,
			logic [CNT_W-1:0] cnt);
		logic [63:0] q;
		if (cnt == '0)
			return '0;
		q = ({30'd0, sum} << FRAC_BITS) / {41'd0, cnt};
		if (q > 64'd32767)
			return '1;
		return q[CENT_W-1:0];
	endfunction

	// markers in order, each testing the pixel as left by the ones before
	task automatic track_pixel(input in_data_t d, input logic eof);
		pix_t    px;
		logic    hit;
		result_t r;
		px = d.px;
		for (int m = 0; m < NUM_MK; m++) begin
			hit = 1'b1;
			for (int c = 0; c < NUM_CH; c++) begin
				if (px[c] < box_reg[m][CH_W*c +: CH_W] || px[c] > box_reg[m][CH_W*(c+3) +: CH_W])
					hit = 1'b0;
			end
			if (hit) begin
				if (hit_tally[m] != CNT_MAX) begin
					col_sum[m]   = col_sum[m] + SUM_W'(d.col);
					row_sum[m]   = row_sum[m] + SUM_W'(d.row);
					hit_tally[m] = hit_tally[m] + 1'b1;
				end
				px = '0;
			end
		end
		r      = '0;
		r.kind = KIND_PIXEL;
		r.last = ~eof;
		r.d.px = px;
		pending_results.push_back(r);
		if (eof) begin
			for (int m = 0; m < NUM_MK; m++) begin
				r             = '0;
				r.kind        = KIND_REC;
				r.last        = (m == NUM_MK - 1);
				r.d.marker    = MK_W'(m);
				r.d.cx        = scaled_mean(col_sum[m], hit_tally[m]);
				r.d.cy        = scaled_mean(row_sum[m], hit_tally[m]);
				r.d.hit_count = hit_tally[m];
				r.d.no_hits   = (hit_tally[m] == '0);
				pending_results.push_back(r);
			end
			for (int m = 0; m < NUM_MK; m++) begin
				col_sum[m]   = '0;
				row_sum[m]   = '0;
				hit_tally[m] = '0;
			end
		end
	endtask

	task automatic send_pixel(input in_data_t d, input logic eof, input logic typed,
			input pix_t echo_px);
		int slot;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
		end
		s_tdata  <= d;
		s_tlast  <= eof;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		pix_accepted++;
		slot = pending_results.size();
		track_pixel(d, eof);
		if (typed)
			pending_results[slot].d.px = echo_px;
	endtask

	// boxes change only once the block has drained
	task automatic write_box(input int idx, input logic [BOX_W-1:0] val);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= MK_W'(idx);
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		box_reg[idx] = val;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t   want;
		out_data_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual kind %0d data %0h",
					$time, m_tuser, m_tdata);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser));
				check_field("last", 64'(want.last), 64'(m_tlast));
				check_field("pixel", 64'(want.d.px), 64'(got.px));
				check_field("marker", 64'(want.d.marker), 64'(got.marker));
				check_field("centroid_x", 64'(want.d.cx), 64'(got.cx));
				check_field("centroid_y", 64'(want.d.cy), 64'(got.cy));
				check_field("hit_count", 64'(want.d.hit_count), 64'(got.hit_count));
				check_field("no_hits", 64'(want.d.no_hits), 64'(got.no_hits));
			end
		end
	end

	// receiver stall pattern in a random style, picked anew on a regular schedule of rx_cyc
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc % 48 == 0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		if (rx_hold)
			m_tready <= 1'b0;
		else case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (rx_cyc % 5) != 2;
			default:     m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// long receiver hold-off while pixels keep coming, to back up the input
	initial begin
		wait (pix_accepted >= 70);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		in_data_t         d;
		logic [BOX_W-1:0] bx;
		logic [CH_W-1:0]  lo;
		logic [CH_W-1:0]  hi;
		int               rand_sent;
		int               mode;
		int               empty_ch;
		int               n_frames;
		int               frame_len;
		int               mk;
		for (int m = 0; m < NUM_MK; m++) begin
			box_reg[m]   = BOX_RESET[m];
			col_sum[m]   = '0;
			row_sum[m]   = '0;
			hit_tally[m] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].is_cfg) begin
				write_box(int'(stim_tab[i].idx), stim_tab[i].box);
			end else begin
				d     = '0;
				d.px  = {stim_tab[i].c2, stim_tab[i].c1, stim_tab[i].c0};
				d.col = stim_tab[i].col;
				d.row = stim_tab[i].row;
				send_pixel(d, stim_tab[i].eof, stim_tab[i].typed,
					{stim_tab[i].e2, stim_tab[i].e1, stim_tab[i].e0});
			end
		end

		rand_sent = 0;
		while (rand_sent < 165) begin
			for (int k = 0; k < NUM_MK; k++) begin
				bx       = '0;
				mode     = $urandom_range(0, 9);
				empty_ch = $urandom_range(0, NUM_CH - 1);
				for (int c = 0; c < NUM_CH; c++) begin
					if (mode == 1) begin
						lo = '0;
						hi = '1;
					end else begin
						lo = CH_W'($urandom_range(0, 230));
						hi = CH_W'($urandom_range(lo, 255));
					end
					// inverted channel makes the box unmatchable
					if (mode == 0 && c == empty_ch) begin
						lo = CH_W'($urandom_range(1, 255));
						hi = CH_W'($urandom_range(0, lo - 1));
					end
					bx[CH_W*c +: CH_W]     = lo;
					bx[CH_W*(c+3) +: CH_W] = hi;
				end
				write_box(k, bx);
			end
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames; f++) begin
				frame_len = $urandom_range(1, 10);
				for (int p = 0; p < frame_len; p++) begin
					d = '0;
					if ($urandom_range(0, 9) < 7) begin
						mk = $urandom_range(0, NUM_MK - 1);
						for (int c = 0; c < NUM_CH; c++)
							d.px[c] = CH_W'($urandom_range(box_reg[mk][CH_W*c +: CH_W],
								box_reg[mk][CH_W*(c+3) +: CH_W]));
					end else begin
						d.px = 24'($urandom);
					end
					if ($urandom_range(0, 6) == 0)
						d.col = ($urandom_range(0, 1) == 0) ? '0 : '1;
					else
						d.col = CRD_W'($urandom_range(0, 2047));
					if ($urandom_range(0, 6) == 0)
						d.row = ($urandom_range(0, 1) == 0) ? '0 : '1;
					else
						d.row = CRD_W'($urandom_range(0, 2047));
					send_pixel(d, p == frame_len - 1, 1'b0, '0);
					rand_sent++;
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
